/* hw/rtl/isb_pkg.sv */
// ============================================================================
// isb_pkg
// Shared widths, defaults and types for the in-order issue scoreboard.
// ============================================================================
package isb_pkg;

    localparam int NUM_REGS_DEF   = 64;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int IDX_W      = 6;
    localparam int IDX_COUNT  = 1 << IDX_W;
    localparam int LAT_W      = 8;
    localparam int TAG_W      = 8;
    localparam int CNT_W      = 16;
    localparam int OUT_TIME_W = 32;

    typedef struct packed {
        logic blk_a;
        logic blk_b;
    } isb_flags_t;

endpackage

/* hw/rtl/in_order_issue_scoreboard.sv */
// ============================================================================
// in_order_issue_scoreboard
// Register scoreboard for an in-order issue model.
// ============================================================================
// Takes one instruction per clock unless stalled and returns one result per
// instruction. The input transfer edge reads both source ready cycles from
// the scoreboard RAM (registered read) into stage 1, which computes issue and
// ready cycles; when the result register is free or being emptied, stage 1
// writes the destination entry and loads the result register, which drives the
// outputs. A write from the instruction ahead is forwarded to the one behind
// it, and per-entry valid bits make unwritten entries read as ready at cycle
// zero, so no clearing pass is needed after reset. Sustained rate is one
// instruction per cycle; the input stalls only while both the first stage and
// the result register hold an instruction and the output is stalled.
module in_order_issue_scoreboard #(
    parameter int NUM_REGS   = isb_pkg::NUM_REGS_DEF,
    parameter int TIME_WIDTH = isb_pkg::TIME_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [isb_pkg::IDX_W-1:0]        dest_index,
    input  logic [isb_pkg::IDX_W-1:0]        src_a_index,
    input  logic [isb_pkg::IDX_W-1:0]        src_b_index,
    input  logic [isb_pkg::LAT_W-1:0]        exec_latency,
    input  logic [isb_pkg::TAG_W-1:0]        opcode_tag,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [isb_pkg::CNT_W-1:0]        instr_number,
    output logic [isb_pkg::TAG_W-1:0]        opcode_echo,
    output logic [isb_pkg::OUT_TIME_W-1:0]   issue_time,
    output logic [isb_pkg::OUT_TIME_W-1:0]   stall_count,
    output logic [isb_pkg::OUT_TIME_W-1:0]   ready_time,
    output logic                             blocked_by_a,
    output logic                             blocked_by_b
);

    localparam int ADDR_W = $clog2(NUM_REGS);

    logic [ADDR_W-1:0] slot_lut [isb_pkg::IDX_COUNT];

    for (genvar i = 0; i < isb_pkg::IDX_COUNT; i++)
    begin : g_slot
        assign slot_lut[i] = ADDR_W'(i % NUM_REGS);
    end

    logic in_xfer;
    logic s1_fire;
    logic [ADDR_W-1:0] in_slot_a;
    logic [ADDR_W-1:0] in_slot_b;

    logic                           s1_valid_reg;
    logic [ADDR_W-1:0]              s1_slot_d_reg;
    logic [isb_pkg::LAT_W-1:0]      s1_lat_reg;
    logic [isb_pkg::TAG_W-1:0]      s1_tag_reg;
    logic                           fwd_a_reg;
    logic                           fwd_b_reg;
    logic [TIME_WIDTH-1:0]          fwd_data_reg;
    logic                           vld_a_reg;
    logic                           vld_b_reg;

    logic [NUM_REGS-1:0]            valid_reg;
    logic [NUM_REGS-1:0]            valid_next;
    logic [TIME_WIDTH-1:0]          earliest_reg;
    logic [isb_pkg::CNT_W-1:0]      instr_counter_reg;

    logic [TIME_WIDTH-1:0]          ram_a;
    logic [TIME_WIDTH-1:0]          ram_b;
    logic [TIME_WIDTH-1:0]          op_a;
    logic [TIME_WIDTH-1:0]          op_b;
    logic [TIME_WIDTH-1:0]          s1_issue;
    logic [TIME_WIDTH-1:0]          s1_stall;
    logic [TIME_WIDTH-1:0]          s1_ready;
    logic [TIME_WIDTH-1:0]          s1_earliest_next;
    isb_pkg::isb_flags_t            s1_flags;

    logic                           out_valid_reg;
    logic [isb_pkg::CNT_W-1:0]      out_num_reg;
    logic [isb_pkg::TAG_W-1:0]      out_tag_reg;
    logic [isb_pkg::OUT_TIME_W-1:0] out_issue_reg;
    logic [isb_pkg::OUT_TIME_W-1:0] out_stall_reg;
    logic [isb_pkg::OUT_TIME_W-1:0] out_ready_reg;
    isb_pkg::isb_flags_t            out_flags_reg;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_xfer  = in_valid && !in_stall;

    assign in_slot_a = slot_lut[src_a_index];
    assign in_slot_b = slot_lut[src_b_index];

    isb_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_ready_ram (
        .clk     (clk),
        .we      (s1_fire),
        .waddr   (s1_slot_d_reg),
        .wdata   (s1_ready),
        .re      (in_xfer),
        .raddr_a (in_slot_a),
        .raddr_b (in_slot_b),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    assign op_a = fwd_a_reg ? fwd_data_reg : (vld_a_reg ? ram_a : '0);
    assign op_b = fwd_b_reg ? fwd_data_reg : (vld_b_reg ? ram_b : '0);

    isb_issue_calc #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_calc (
        .earliest      (earliest_reg),
        .ready_a       (op_a),
        .ready_b       (op_b),
        .latency       (s1_lat_reg),
        .issue         (s1_issue),
        .stall         (s1_stall),
        .ready         (s1_ready),
        .earliest_next (s1_earliest_next),
        .flags         (s1_flags)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (s1_fire)
        begin
            valid_next[s1_slot_d_reg] = 1'b1;
        end
    end

    // Stage 1 and result register control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            fwd_a_reg         <= 1'b0;
            fwd_b_reg         <= 1'b0;
            vld_a_reg         <= 1'b0;
            vld_b_reg         <= 1'b0;
            valid_reg         <= '0;
            earliest_reg      <= '0;
            instr_counter_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
                fwd_a_reg    <= s1_fire && (s1_slot_d_reg == in_slot_a);
                fwd_b_reg    <= s1_fire && (s1_slot_d_reg == in_slot_b);
                vld_a_reg    <= valid_reg[in_slot_a];
                vld_b_reg    <= valid_reg[in_slot_b];
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                earliest_reg      <= s1_earliest_next;
                instr_counter_reg <= instr_counter_reg + isb_pkg::CNT_W'(1);
                out_valid_reg     <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_slot_d_reg <= slot_lut[dest_index];
            s1_lat_reg    <= exec_latency;
            s1_tag_reg    <= opcode_tag;
            fwd_data_reg  <= s1_ready;
        end
        if (s1_fire)
        begin
            out_num_reg   <= instr_counter_reg;
            out_tag_reg   <= s1_tag_reg;
            out_issue_reg <= isb_pkg::OUT_TIME_W'(s1_issue);
            out_stall_reg <= isb_pkg::OUT_TIME_W'(s1_stall);
            out_ready_reg <= isb_pkg::OUT_TIME_W'(s1_ready);
            out_flags_reg <= s1_flags;
        end
    end

    assign out_valid    = out_valid_reg;
    assign instr_number = out_num_reg;
    assign opcode_echo  = out_tag_reg;
    assign issue_time   = out_issue_reg;
    assign stall_count  = out_stall_reg;
    assign ready_time   = out_ready_reg;
    assign blocked_by_a = out_flags_reg.blk_a;
    assign blocked_by_b = out_flags_reg.blk_b;

`ifndef SYNTH
    a_issue_not_early: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_issue >= earliest_reg)
        else $error("issue cycle before earliest issue cycle");

    a_dest_marked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> valid_reg[$past(s1_slot_d_reg)])
        else $error("written entry not marked valid");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> instr_counter_reg == $past(instr_counter_reg) + isb_pkg::CNT_W'(1))
        else $error("instruction counter did not advance by one");

    a_earliest_grows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (earliest_reg > $past(earliest_reg)) || (earliest_reg == '1))
        else $error("earliest issue cycle did not advance");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg && !s1_valid_reg || s1_valid_reg && $past(in_xfer))
        else $error("stage 1 and result register out of step");
`endif

endmodule

/* hw/rtl/isb_ram.sv */
// ============================================================================
// isb_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
module isb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hw/rtl/isb_issue_calc.sv */
// ============================================================================
// isb_issue_calc
// Issue cycle, blocking flags, stall and saturating ready cycle of one
// instruction from its operand ready cycles and the earliest issue cycle.
// ============================================================================
module isb_issue_calc #(
    parameter int TIME_WIDTH = isb_pkg::TIME_WIDTH_DEF
) (
    input  logic [TIME_WIDTH-1:0]       earliest,
    input  logic [TIME_WIDTH-1:0]       ready_a,
    input  logic [TIME_WIDTH-1:0]       ready_b,
    input  logic [isb_pkg::LAT_W-1:0]   latency,
    output logic [TIME_WIDTH-1:0]       issue,
    output logic [TIME_WIDTH-1:0]       stall,
    output logic [TIME_WIDTH-1:0]       ready,
    output logic [TIME_WIDTH-1:0]       earliest_next,
    output isb_pkg::isb_flags_t         flags
);

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    logic [TIME_WIDTH-1:0] issue_ab;
    logic [TIME_WIDTH:0]   ready_sum;
    logic [TIME_WIDTH:0]   next_sum;

    always_comb
    begin
        flags.blk_a = ready_a > earliest;
        flags.blk_b = ready_b > earliest;

        issue_ab = (ready_a > ready_b) ? ready_a : ready_b;
        issue    = (flags.blk_a || flags.blk_b) ? issue_ab : earliest;
        stall    = issue - earliest;

        ready_sum = {1'b0, issue} + (TIME_WIDTH + 1)'(latency);
        ready     = ready_sum[TIME_WIDTH] ? TIME_MAX : ready_sum[TIME_WIDTH-1:0];

        next_sum      = {1'b0, issue} + (TIME_WIDTH + 1)'(1);
        earliest_next = next_sum[TIME_WIDTH] ? TIME_MAX : next_sum[TIME_WIDTH-1:0];
    end

endmodule
